// ----- hdl/vbd_pkg.sv -----
package vbd_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int BYTE_WIDTH  = 8;
   localparam int GROUP_BITS  = 7;
   localparam int COUNT_WIDTH = 3;
   localparam int MAX_GROUPS  = 5;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENC_EMIT,
      ST_DEC_EMIT
   } state_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] in_value;
      logic [BYTE_WIDTH-1:0]  in_byte;
      logic                   start_of_list;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  out_byte;
      logic [VALUE_WIDTH-1:0] out_value;
      logic                   last;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic shift;
   } enc_ctrl_type;

   typedef struct packed {
      logic take;
      logic start;
   } dec_ctrl_type;

endpackage

// ----- hdl/vbd_encoder.sv -----
module vbd_encoder (
   input  logic                             clock,
   input  vbd_pkg::enc_ctrl_type            ctrl,
   input  logic [vbd_pkg::VALUE_WIDTH-1:0]  in_value,
   input  logic [vbd_pkg::VALUE_WIDTH-1:0]  prev_plus_one,
   output logic [vbd_pkg::BYTE_WIDTH-1:0]   out_byte,
   output logic                             out_last
);

   logic [vbd_pkg::VALUE_WIDTH-1:0] gap_ff;
   logic [vbd_pkg::VALUE_WIDTH-1:0] gap_in;

   // The gap leaves the shift register seven bits at a time, low group first.
   always_comb begin
      gap_in = gap_ff;
      if (ctrl.load) begin
         gap_in = in_value - prev_plus_one;
      end else if (ctrl.shift) begin
         gap_in = gap_ff >> vbd_pkg::GROUP_BITS;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
   end

   assign out_last = (gap_ff[vbd_pkg::VALUE_WIDTH-1:vbd_pkg::GROUP_BITS] == '0);
   assign out_byte = {out_last, gap_ff[vbd_pkg::GROUP_BITS-1:0]};

endmodule

// ----- hdl/vbd_decoder.sv -----
module vbd_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  vbd_pkg::dec_ctrl_type            ctrl,
   input  logic [vbd_pkg::BYTE_WIDTH-1:0]   in_byte,
   input  logic [vbd_pkg::VALUE_WIDTH-1:0]  prev_plus_one,
   output logic [vbd_pkg::VALUE_WIDTH-1:0]  sum
);

   logic [vbd_pkg::VALUE_WIDTH-1:0] partial_ff;
   logic [vbd_pkg::VALUE_WIDTH-1:0] partial_in;
   logic [vbd_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [vbd_pkg::COUNT_WIDTH-1:0] count_in;
   logic [vbd_pkg::VALUE_WIDTH-1:0] sum_ff;
   logic [vbd_pkg::VALUE_WIDTH-1:0] sum_in;

   logic [vbd_pkg::VALUE_WIDTH-1:0] partial_base;
   logic [vbd_pkg::COUNT_WIDTH-1:0] count_base;
   logic [vbd_pkg::VALUE_WIDTH-1:0] group_word;
   logic [vbd_pkg::VALUE_WIDTH-1:0] partial_new;
   logic [vbd_pkg::GROUP_BITS-1:0]  group;

   assign group        = in_byte[vbd_pkg::GROUP_BITS-1:0];
   assign partial_base = ctrl.start ? '0 : partial_ff;
   assign count_base   = ctrl.start ? '0 : count_ff;

   // Each group lands in its own seven-bit field, so placing it is enough.
   // The fifth group keeps only the bits that still fit in the word.
   always_comb begin
      case (count_base)
         3'd0:    group_word = {25'b0, group};
         3'd1:    group_word = {18'b0, group, 7'b0};
         3'd2:    group_word = {11'b0, group, 14'b0};
         3'd3:    group_word = {4'b0, group, 21'b0};
         3'd4:    group_word = {group[3:0], 28'b0};
         default: group_word = '0;
      endcase
   end

   assign partial_new = partial_base | group_word;

   always_comb begin
      partial_in = partial_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      if (ctrl.take) begin
         if (in_byte[vbd_pkg::BYTE_WIDTH-1]) begin
            sum_in     = partial_new + prev_plus_one;
            partial_in = '0;
            count_in   = '0;
         end else begin
            partial_in = partial_new;
            if (count_base < vbd_pkg::COUNT_WIDTH'(vbd_pkg::MAX_GROUPS)) begin
               count_in = count_base + 1'b1;
            end else begin
               count_in = count_base;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         count_ff   <= '0;
      end else begin
         partial_ff <= partial_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

// ----- hdl/varbyte_delta_codec.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  in_value, in_byte, start_of_list
// rsp_      out        rsp_valid / rsp_ready  out_byte, out_value, last
// csr_      in         csr_write_enable       mode (csr_write_data)
//
// Encode: an accepted request loads the gap register, which then shifts out one
// to five coded bytes of seven gap bits each; no new request is taken meanwhile.
// Decode: a non-final byte extends the partial gap; a final byte yields a value.
// Reset is synchronous and clears mode, the previous value and the decoder's
// partial gap. A stalled response holds in the output register and stops the
// shift-out until it is taken.
module varbyte_delta_codec (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  vbd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vbd_pkg::rsp_payload_type rsp_payload
);

   vbd_pkg::state_type state_ff;
   vbd_pkg::state_type state_in;

   logic                            mode_ff;
   logic [vbd_pkg::VALUE_WIDTH-1:0] prev_ff;
   logic [vbd_pkg::VALUE_WIDTH-1:0] prev_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   vbd_pkg::rsp_payload_type        rsp_payload_ff;
   vbd_pkg::rsp_payload_type        rsp_payload_in;

   logic                            accept;
   logic                            out_free;
   logic                            enc_emit;
   logic                            dec_emit;
   logic [vbd_pkg::VALUE_WIDTH-1:0] prev_eff;
   vbd_pkg::enc_ctrl_type           enc_ctrl;
   vbd_pkg::dec_ctrl_type           dec_ctrl;
   logic [vbd_pkg::BYTE_WIDTH-1:0]  enc_byte;
   logic                            enc_last;
   logic [vbd_pkg::VALUE_WIDTH-1:0] dec_sum;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign prev_eff = req_payload.start_of_list ? '0 : prev_ff;

   vbd_encoder u_encoder (
      .clock         (clock),
      .ctrl          (enc_ctrl),
      .in_value      (req_payload.in_value),
      .prev_plus_one (prev_eff),
      .out_byte      (enc_byte),
      .out_last      (enc_last)
   );

   vbd_decoder u_decoder (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (dec_ctrl),
      .in_byte       (req_payload.in_byte),
      .prev_plus_one (prev_eff),
      .sum           (dec_sum)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vbd_pkg::ST_IDLE: begin
            if (accept) begin
               if (mode_ff == vbd_pkg::MODE_ENCODE) begin
                  state_in = vbd_pkg::ST_ENC_EMIT;
               end else if (req_payload.in_byte[vbd_pkg::BYTE_WIDTH-1]) begin
                  state_in = vbd_pkg::ST_DEC_EMIT;
               end
            end
         end
         vbd_pkg::ST_ENC_EMIT: begin
            if (out_free && enc_last) begin
               state_in = vbd_pkg::ST_IDLE;
            end
         end
         vbd_pkg::ST_DEC_EMIT: begin
            if (out_free) begin
               state_in = vbd_pkg::ST_IDLE;
            end
         end
         default: state_in = vbd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      enc_emit       = 1'b0;
      dec_emit       = 1'b0;
      unique case (state_ff)
         vbd_pkg::ST_IDLE:     req_ready = 1'b1;
         vbd_pkg::ST_ENC_EMIT: enc_emit  = out_free;
         vbd_pkg::ST_DEC_EMIT: dec_emit  = out_free;
         default:              req_ready = 1'b0;
      endcase
      enc_ctrl.load  = accept && (mode_ff == vbd_pkg::MODE_ENCODE);
      enc_ctrl.shift = enc_emit;
      dec_ctrl.take  = accept && (mode_ff == vbd_pkg::MODE_DECODE);
      dec_ctrl.start = req_payload.start_of_list;
   end

   always_comb begin
      prev_in = prev_ff;
      if (enc_ctrl.load) begin
         prev_in = req_payload.in_value + 1'b1;
      end else if (dec_ctrl.take && dec_ctrl.start) begin
         prev_in = '0;
      end else if (dec_emit) begin
         prev_in = dec_sum + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (enc_emit) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.out_byte  = enc_byte;
         rsp_payload_in.out_value = '0;
         rsp_payload_in.last      = enc_last;
      end else if (dec_emit) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.out_byte  = '0;
         rsp_payload_in.out_value = dec_sum;
         rsp_payload_in.last      = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vbd_pkg::ST_IDLE;
         mode_ff      <= vbd_pkg::MODE_ENCODE;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_enc_enters_emit: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == vbd_pkg::MODE_ENCODE) |=> state_ff == vbd_pkg::ST_ENC_EMIT)
      else $error("encode request did not start the byte shift-out");

   a_enc_last_ends: assert property (@(posedge clock) disable iff (reset)
      (enc_emit && enc_last) |=>
         (state_ff == vbd_pkg::ST_IDLE && rsp_valid_ff && rsp_payload_ff.last))
      else $error("final coded byte did not close the value");

   a_dec_result_form: assert property (@(posedge clock) disable iff (reset)
      dec_emit |=>
         (rsp_valid_ff && rsp_payload_ff.last && rsp_payload_ff.out_byte == '0))
      else $error("decoded value response is malformed");

   a_enc_mid_byte: assert property (@(posedge clock) disable iff (reset)
      (enc_emit && !enc_last) |=>
         (state_ff == vbd_pkg::ST_ENC_EMIT && !rsp_payload_ff.last &&
          !rsp_payload_ff.out_byte[vbd_pkg::BYTE_WIDTH-1]))
      else $error("continuation byte carries the final flag");

endmodule
